// ===== rtl/core/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants shared by the hash table core and its key hash unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_HASH_SEED      = 2'd0;
  localparam logic [1:0] CFG_ENTRIES_IN_USE = 2'd1;
  localparam logic [1:0] CFG_KEY_ROOM       = 2'd2;

  // Operation codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_FIND   = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_PRESENT   = 3'd3,
    ST_FULL      = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  // MurmurHash3 x86_32 constants
  localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2  = 32'h1b873593;
  localparam logic [31:0] MM_ADD = 32'he6546b64;
  localparam logic [31:0] MM_F1  = 32'h85ebca6b;
  localparam logic [31:0] MM_F2  = 32'hc2b2ae35;

  // Hash unit sequencer
  typedef enum logic [3:0] {
    H_IDLE,
    H_K1,
    H_K2,
    H_MIX,
    H_F1,
    H_F2,
    H_F3,
    H_DIV,
    H_DONE
  } hash_state_t;

  // Table sequencer
  typedef enum logic [2:0] {
    T_CLEAR,
    T_IDLE,
    T_HASH,
    T_RD,
    T_CMP,
    T_OUT
  } tbl_state_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    rotl32 = (x << r) | (x >> (32 - r));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lpht_hash.sv =====
// ----------------------------------------------------------------------------
// lpht_hash
// Key hash and home slot: MurmurHash3 x86_32 on one shared multiplier, then
// a restoring remainder by the slot count, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_hash #(
  parameter int NW = 11,
  parameter int AW = 10
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [63:0]   key,
  input  wire logic [3:0]    len,
  input  wire logic [31:0]   seed,
  input  wire logic [NW-1:0] n,
  output logic               done,
  output logic [AW-1:0]      home
);
  import lpht_pkg::*;

  hash_state_t   state_r, state_nxt;
  logic [31:0]   h_r, h_nxt;
  logic [31:0]   k_r, k_nxt;
  logic [63:0]   key_r, key_nxt;
  logic [3:0]    len_r, len_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          blk_r, blk_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [4:0]    cnt_r, cnt_nxt;

  logic [31:0]   mul_a, mul_b, prod;
  logic [4:0]    len_up;
  logic [3:0]    blk_end;
  logic          two_rounds;
  logic          full_blk;
  logic [NW:0]   rem_sh;

  // shared multiplier, low word only
  assign prod = mul_a * mul_b;

  assign len_up     = {1'b0, len_r} + 5'd3;
  assign two_rounds = (len_up[4:2] == 3'd2);
  assign blk_end    = {1'b0, blk_r, 2'b00} + 4'd4;
  assign full_blk   = (blk_end <= len_r);
  assign rem_sh     = {rem_r, h_r[31]};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      H_IDLE: if (start) state_nxt = (len == 4'd0) ? H_F1 : H_K1;
      H_K1:   state_nxt = H_K2;
      H_K2:   state_nxt = H_MIX;
      H_MIX:  state_nxt = (!blk_r && two_rounds) ? H_K1 : H_F1;
      H_F1:   state_nxt = H_F2;
      H_F2:   state_nxt = H_F3;
      H_F3:   state_nxt = H_DIV;
      H_DIV:  if (cnt_r == 5'd31) state_nxt = H_DONE;
      H_DONE: state_nxt = H_IDLE;
      default: state_nxt = H_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    logic [31:0] hx;
    logic [31:0] hr;
    logic [31:0] fx;
    h_nxt   = h_r;
    k_nxt   = k_r;
    key_nxt = key_r;
    len_nxt = len_r;
    n_nxt   = n_r;
    blk_nxt = blk_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    mul_a   = '0;
    mul_b   = '0;
    hx      = h_r ^ k_r;
    hr      = rotl32(hx, 13);
    fx      = '0;
    unique case (state_r)
      H_IDLE: begin
        if (start) begin
          h_nxt   = seed;
          key_nxt = key;
          len_nxt = len;
          n_nxt   = n;
          blk_nxt = 1'b0;
        end
      end
      H_K1: begin
        mul_a = blk_r ? key_r[63:32] : key_r[31:0];
        mul_b = MM_C1;
        k_nxt = prod;
      end
      H_K2: begin
        mul_a = rotl32(k_r, 15);
        mul_b = MM_C2;
        k_nxt = prod;
      end
      H_MIX: begin
        // full block rotates and scales, tail block only folds in
        h_nxt   = full_blk ? ((hr << 2) + hr + MM_ADD) : hx;
        blk_nxt = ~blk_r;
      end
      H_F1: begin
        fx    = h_r ^ {28'd0, len_r};
        mul_a = fx ^ (fx >> 16);
        mul_b = MM_F1;
        h_nxt = prod;
      end
      H_F2: begin
        mul_a = h_r ^ (h_r >> 13);
        mul_b = MM_F2;
        h_nxt = prod;
      end
      H_F3: begin
        h_nxt   = h_r ^ (h_r >> 16);
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      H_DIV: begin
        // one remainder bit a cycle, hash shifts out msb first
        if (rem_sh >= {1'b0, n_r}) begin
          rem_nxt = NW'(rem_sh - {1'b0, n_r});
        end else begin
          rem_nxt = rem_sh[NW-1:0];
        end
        h_nxt   = h_r << 1;
        cnt_nxt = cnt_r + 5'd1;
      end
      H_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    h_r   <= h_nxt;
    k_r   <= k_nxt;
    key_r <= key_nxt;
    len_r <= len_nxt;
    n_r   <= n_nxt;
    blk_r <= blk_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = (state_r == H_DONE);
  assign home = rem_r[AW-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with short byte-string keys and linear probing.
// ----------------------------------------------------------------------------
// Each beat is an insert or a find and gives one result beat. The key is
// hashed with MurmurHash3 x86_32 on one shared multiplier, reduced modulo
// the slot count by a bit-serial remainder unit, and then the table is
// walked one probed slot at a time (one registered memory read, then one
// compare per slot). A key that is too long skips the hash and the walk and
// goes straight to its result beat. After reset a clearing pass over every
// slot marks each one free before the first beat is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_BITS  = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata,
  // input channel
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         in_mode,
  input  wire logic [63:0]  in_key_bytes,
  input  wire logic [3:0]   in_key_length,
  input  wire logic [31:0]  in_value_in,
  input  wire logic         in_value_given,
  // result channel
  output logic              out_valid,
  input  wire logic         out_ready,
  output lpht_pkg::status_t out_status,
  output logic [9:0]        out_slot,
  output logic [31:0]       out_value_out
);
  import lpht_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = KEY_BYTES * 8;
  localparam int VW = VALUE_BITS;

  // configuration registers
  logic [31:0] seed_r;
  logic [10:0] entries_r;
  logic [3:0]  key_room_r;

  // table memory
  logic          occ_mem [TABLE_DEPTH];
  logic [3:0]    klen_mem [TABLE_DEPTH];
  logic [KW-1:0] key_mem [TABLE_DEPTH];
  logic [VW-1:0] val_mem [TABLE_DEPTH];
  logic          occ_q;
  logic [3:0]    klen_q;
  logic [KW-1:0] key_q;
  logic [VW-1:0] val_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic          mem_wocc;

  tbl_state_t    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] probe_r, probe_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          mode_r, mode_nxt;
  logic [63:0]   key_r, key_nxt;
  logic [3:0]    len_r, len_nxt;
  logic [3:0]    zpos_r, zpos_nxt;
  logic [VW-1:0] wval_r, wval_nxt;
  status_t       status_r, status_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [VW-1:0] vout_r, vout_nxt;

  logic          in_fire, out_fire;
  logic          too_long;
  logic [63:0]   key_m;
  logic [3:0]    zpos_m;
  logic [NW-1:0] n_m;
  logic [63:0]   vin_ext;
  logic          hash_start, hash_done;
  logic [AW-1:0] hash_home;
  logic          key_hit;
  logic          last_probe;
  logic          wrap;
  logic [31:0]   slot_ext;
  logic [63:0]   vout_ext;

  assign in_ready  = (state_r == T_IDLE);
  assign out_valid = (state_r == T_OUT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= '0;
      entries_r  <= 11'd1024;
      key_room_r <= 4'd9;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HASH_SEED:      seed_r     <= cfg_wdata;
        CFG_ENTRIES_IN_USE: entries_r  <= cfg_wdata[10:0];
        CFG_KEY_ROOM:       key_room_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // clamp slot count, mask key to its length, find first zero byte
  always_comb begin
    logic found;
    if (entries_r == 11'd0) begin
      n_m = NW'(1);
    end else if (32'(entries_r) > TABLE_DEPTH) begin
      n_m = NW'(TABLE_DEPTH);
    end else begin
      n_m = NW'(entries_r);
    end
    found  = 1'b0;
    zpos_m = in_key_length;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(in_key_length)) begin
        key_m[8*i +: 8] = in_key_bytes[8*i +: 8];
        if (!found && in_key_bytes[8*i +: 8] == 8'd0) begin
          zpos_m = 4'(i);
          found  = 1'b1;
        end
      end else begin
        key_m[8*i +: 8] = 8'd0;
      end
    end
  end

  assign too_long   = (in_key_length >= key_room_r) || (32'(in_key_length) > KEY_BYTES);
  assign vin_ext    = 64'(in_value_in);
  assign hash_start = in_fire && !too_long;

  lpht_hash #(
    .NW(NW),
    .AW(AW)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (key_m),
    .len   (in_key_length),
    .seed  (seed_r),
    .n     (n_m),
    .done  (hash_done),
    .home  (hash_home)
  );

  assign key_hit    = (klen_q == len_r) && (64'(key_q) == key_r);
  assign last_probe = (cnt_r == n_r - NW'(1));
  assign wrap       = (32'(probe_r) + 32'd1 >= 32'(n_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_CLEAR: if (clr_r == AW'(TABLE_DEPTH - 1)) state_nxt = T_IDLE;
      T_IDLE:  if (in_fire) state_nxt = too_long ? T_OUT : T_HASH;
      T_HASH:  if (hash_done) state_nxt = T_RD;
      T_RD:    state_nxt = T_CMP;
      T_CMP:   state_nxt = (!occ_q || key_hit || last_probe) ? T_OUT : T_RD;
      T_OUT:   if (out_fire) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  // datapath and memory write control
  always_comb begin
    clr_nxt    = clr_r;
    probe_nxt  = probe_r;
    cnt_nxt    = cnt_r;
    n_nxt      = n_r;
    mode_nxt   = mode_r;
    key_nxt    = key_r;
    len_nxt    = len_r;
    zpos_nxt   = zpos_r;
    wval_nxt   = wval_r;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    vout_nxt   = vout_r;
    mem_we     = 1'b0;
    mem_wa     = probe_r;
    mem_wocc   = 1'b1;
    unique case (state_r)
      T_CLEAR: begin
        mem_we   = 1'b1;
        mem_wa   = clr_r;
        mem_wocc = 1'b0;
        clr_nxt  = clr_r + AW'(1);
      end
      T_IDLE: begin
        if (in_fire) begin
          mode_nxt   = in_mode;
          key_nxt    = key_m;
          len_nxt    = in_key_length;
          zpos_nxt   = zpos_m;
          n_nxt      = n_m;
          // a value that is not given stores zero
          wval_nxt   = in_value_given ? vin_ext[VW-1:0] : '0;
          status_nxt = ST_TOO_LONG;
          slot_nxt   = '0;
          vout_nxt   = '0;
        end
      end
      T_HASH: begin
        if (hash_done) begin
          probe_nxt = hash_home;
          cnt_nxt   = '0;
        end
      end
      T_RD: ;
      T_CMP: begin
        if (!occ_q) begin
          if (mode_r == MODE_INSERT) begin
            mem_we     = 1'b1;
            status_nxt = ST_INSERTED;
            slot_nxt   = probe_r;
            vout_nxt   = wval_r;
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
        end else if (key_hit) begin
          if (mode_r == MODE_INSERT) begin
            status_nxt = ST_PRESENT;
          end else begin
            status_nxt = ST_FOUND;
            slot_nxt   = probe_r;
            vout_nxt   = val_q;
          end
        end else if (last_probe) begin
          status_nxt = (mode_r == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
        end else begin
          // advance to the next slot, wrapping at the slot count
          probe_nxt = wrap ? '0 : probe_r + AW'(1);
          cnt_nxt   = cnt_r + NW'(1);
        end
      end
      T_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    probe_r  <= probe_nxt;
    cnt_r    <= cnt_nxt;
    n_r      <= n_nxt;
    mode_r   <= mode_nxt;
    key_r    <= key_nxt;
    len_r    <= len_nxt;
    zpos_r   <= zpos_nxt;
    wval_r   <= wval_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    vout_r   <= vout_nxt;
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[mem_wa]  <= mem_wocc;
      klen_mem[mem_wa] <= zpos_r;
      key_mem[mem_wa]  <= key_r[KW-1:0];
      val_mem[mem_wa]  <= wval_r;
    end
    occ_q  <= occ_mem[probe_r];
    klen_q <= klen_mem[probe_r];
    key_q  <= key_mem[probe_r];
    val_q  <= val_mem[probe_r];
  end

  assign slot_ext      = 32'(slot_r);
  assign vout_ext      = 64'(vout_r);
  assign out_status    = status_r;
  assign out_slot      = slot_ext[9:0];
  assign out_value_out = vout_ext[31:0];

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result sides active together");

  a_hash_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> (state_r == T_HASH))
    else $error("hash finished outside hashing phase");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_TOO_LONG || out_status == ST_FULL ||
                   out_status == ST_NOT_FOUND || out_status == ST_PRESENT))
    |-> (out_slot == 10'd0 && out_value_out == 32'd0))
    else $error("failed operation carries slot or value");

  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_RD) |-> (32'(probe_r) < 32'(n_r)))
    else $error("probe beyond slot count");
`endif

endmodule

`default_nettype wire
